// ----- rtl/alex_pkg.sv -----
// shared types and constants for the assignment lexer
// used by alex_front, alex_queue, alex_back and assignment_lexer_core

package alex_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 24;
   localparam int unsigned TEXT_W  = 64;
   localparam int unsigned LEN_W   = 4;

   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_EQUALS  = 8'h3d;
   localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2b;
   localparam logic [BYTE_W-1:0] CHAR_SEMI    = 8'h3b;

   typedef enum logic [2:0] {
      CLS_WHITE  = 3'd0,
      CLS_EQUALS = 3'd1,
      CLS_PLUS   = 3'd2,
      CLS_SEMI   = 3'd3,
      CLS_LETTER = 3'd4,
      CLS_DIGIT  = 3'd5,
      CLS_OTHER  = 3'd6,
      CLS_END    = 3'd7
   } class_type;

   typedef enum logic [2:0] {
      KIND_WHITE  = 3'd0,
      KIND_EQUALS = 3'd1,
      KIND_PLUS   = 3'd2,
      KIND_SEMI   = 3'd3,
      KIND_NAME   = 3'd4,
      KIND_INT    = 3'd5,
      KIND_ERROR  = 3'd6,
      KIND_END    = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_WHITE = 2'd1,
      MODE_NAME  = 2'd2,
      MODE_INT   = 2'd3
   } mode_type;

   typedef struct packed {
      class_type         cls;
      logic [BYTE_W-1:0] char_value;
   } item_type;

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] int_value;
      logic [TEXT_W-1:0]  name_text;
      logic [LEN_W-1:0]   name_length;
      logic [BYTE_W-1:0]  bad_char;
      logic               last_of_run;
   } token_type;

endpackage

// ----- rtl/alex_front.sv -----
// front end: accepts input bytes and end markers and classifies them
// depends on alex_pkg; feeds alex_queue

module alex_front (
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [alex_pkg::BYTE_W-1:0]   req_byte_value,
   input  logic                          req_is_end,
   input  logic                          q_full,
   output logic                          q_push,
   output alex_pkg::item_type            q_item
);

   alex_pkg::class_type cls;

   always_comb begin
      if (req_is_end) begin
         cls = alex_pkg::CLS_END;
      end else if (req_byte_value == alex_pkg::CHAR_SPACE ||
                   req_byte_value == alex_pkg::CHAR_NEWLINE) begin
         cls = alex_pkg::CLS_WHITE;
      end else if (req_byte_value == alex_pkg::CHAR_EQUALS) begin
         cls = alex_pkg::CLS_EQUALS;
      end else if (req_byte_value == alex_pkg::CHAR_PLUS) begin
         cls = alex_pkg::CLS_PLUS;
      end else if (req_byte_value == alex_pkg::CHAR_SEMI) begin
         cls = alex_pkg::CLS_SEMI;
      end else if (req_byte_value inside {[8'h41:8'h5a], [8'h61:8'h7a]}) begin
         cls = alex_pkg::CLS_LETTER;
      end else if (req_byte_value inside {[8'h30:8'h39]}) begin
         cls = alex_pkg::CLS_DIGIT;
      end else begin
         cls = alex_pkg::CLS_OTHER;
      end
   end

   assign req_stall         = q_full;
   assign q_push            = req_valid && !q_full;
   assign q_item.cls        = cls;
   assign q_item.char_value = req_byte_value;

endmodule

// ----- rtl/alex_queue.sv -----
// small fifo of classified items between front and back
// depends on alex_pkg

module alex_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  alex_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output alex_pkg::item_type pop_item,
   output logic               empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   alex_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_FULL) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ----- rtl/alex_back.sv -----
// back end: lexer state, token assembly and result register with spill stage
// depends on alex_pkg; fed by alex_queue

module alex_back #(
   parameter int unsigned NAME_CHARS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  alex_pkg::item_type             q_item,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output alex_pkg::token_type            rsp_token
);

   localparam logic [alex_pkg::LEN_W-1:0] NAME_MAX = alex_pkg::LEN_W'(NAME_CHARS);
   localparam logic [alex_pkg::LEN_W-1:0] INT_MAX  = alex_pkg::LEN_W'(NAME_CHARS - 1);

   alex_pkg::mode_type                 mode_ff, mode_in;
   logic [alex_pkg::TEXT_W-1:0]        buffer_ff, buffer_in;
   logic [alex_pkg::LEN_W-1:0]         count_ff, count_in;
   logic [alex_pkg::VALUE_W-1:0]       accum_ff, accum_in;
   logic                               halted_ff, halted_in;

   logic                               out_valid_ff, out_valid_in;
   alex_pkg::token_type                out_ff, out_in;
   logic                               spill_valid_ff, spill_valid_in;
   alex_pkg::token_type                spill_ff, spill_in;

   alex_pkg::token_type                blank_tok;
   alex_pkg::token_type                flush_tok;
   alex_pkg::token_type                own_tok;
   logic                               flush_use;
   logic                               own_has;
   logic                               flush_emit;
   logic                               out_free;
   logic [alex_pkg::VALUE_W-1:0]       accum_next;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign accum_next = (accum_ff << 3) + (accum_ff << 1)
                       + alex_pkg::VALUE_W'(q_item.char_value[3:0]);

   always_comb begin
      blank_tok.kind        = alex_pkg::KIND_WHITE;
      blank_tok.int_value   = '0;
      blank_tok.name_text   = '0;
      blank_tok.name_length = '0;
      blank_tok.bad_char    = '0;
      blank_tok.last_of_run = 1'b0;

      flush_tok = blank_tok;
      case (mode_ff)
         alex_pkg::MODE_NAME: begin
            flush_tok.kind        = alex_pkg::KIND_NAME;
            flush_tok.name_text   = buffer_ff;
            flush_tok.name_length = count_ff;
         end
         alex_pkg::MODE_INT: begin
            flush_tok.kind      = alex_pkg::KIND_INT;
            flush_tok.int_value = accum_ff;
         end
         default: begin
            flush_tok.kind = alex_pkg::KIND_WHITE;
         end
      endcase
   end

   always_comb begin
      mode_in        = mode_ff;
      buffer_in      = buffer_ff;
      count_in       = count_ff;
      accum_in       = accum_ff;
      halted_in      = halted_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_in         = out_ff;
      spill_valid_in = spill_valid_ff;
      spill_in       = spill_ff;
      q_pop          = 1'b0;
      flush_use      = 1'b0;
      own_has        = 1'b0;
      own_tok        = blank_tok;
      flush_emit     = 1'b0;

      if (out_free) begin
         if (spill_valid_ff) begin
            out_in         = spill_ff;
            out_valid_in   = 1'b1;
            spill_valid_in = 1'b0;
         end else if (!q_empty) begin
            q_pop = 1'b1;
            if (q_item.cls == alex_pkg::CLS_END) begin
               flush_use    = 1'b1;
               own_has      = 1'b1;
               own_tok.kind = alex_pkg::KIND_END;
               halted_in    = 1'b0;
               mode_in      = alex_pkg::MODE_IDLE;
               buffer_in    = '0;
               count_in     = '0;
               accum_in     = '0;
            end else if (!halted_ff) begin
               case (q_item.cls)
                  alex_pkg::CLS_WHITE: begin
                     if (mode_ff != alex_pkg::MODE_WHITE) begin
                        flush_use = 1'b1;
                        mode_in   = alex_pkg::MODE_WHITE;
                        buffer_in = '0;
                        count_in  = '0;
                        accum_in  = '0;
                     end
                  end
                  alex_pkg::CLS_EQUALS, alex_pkg::CLS_PLUS, alex_pkg::CLS_SEMI: begin
                     flush_use = 1'b1;
                     own_has   = 1'b1;
                     case (q_item.cls)
                        alex_pkg::CLS_EQUALS: own_tok.kind = alex_pkg::KIND_EQUALS;
                        alex_pkg::CLS_PLUS:   own_tok.kind = alex_pkg::KIND_PLUS;
                        default:              own_tok.kind = alex_pkg::KIND_SEMI;
                     endcase
                     mode_in   = alex_pkg::MODE_IDLE;
                     buffer_in = '0;
                     count_in  = '0;
                     accum_in  = '0;
                  end
                  alex_pkg::CLS_LETTER: begin
                     if (mode_ff == alex_pkg::MODE_NAME && count_ff < NAME_MAX) begin
                        buffer_in[count_ff[2:0]*8 +: 8] = q_item.char_value;
                        count_in = count_ff + 1'b1;
                     end else begin
                        flush_use = 1'b1;
                        mode_in   = alex_pkg::MODE_NAME;
                        buffer_in = alex_pkg::TEXT_W'(q_item.char_value);
                        count_in  = alex_pkg::LEN_W'(1);
                        accum_in  = '0;
                     end
                  end
                  alex_pkg::CLS_DIGIT: begin
                     if (mode_ff == alex_pkg::MODE_INT && count_ff < INT_MAX) begin
                        accum_in = accum_next;
                        count_in = count_ff + 1'b1;
                     end else begin
                        flush_use = 1'b1;
                        mode_in   = alex_pkg::MODE_INT;
                        buffer_in = '0;
                        count_in  = alex_pkg::LEN_W'(1);
                        accum_in  = alex_pkg::VALUE_W'(q_item.char_value[3:0]);
                     end
                  end
                  default: begin
                     flush_use        = 1'b1;
                     own_has          = 1'b1;
                     own_tok.kind     = alex_pkg::KIND_ERROR;
                     own_tok.bad_char = q_item.char_value;
                     halted_in        = 1'b1;
                     mode_in          = alex_pkg::MODE_IDLE;
                     buffer_in        = '0;
                     count_in         = '0;
                     accum_in         = '0;
                  end
               endcase
            end

            flush_emit = flush_use && (mode_ff != alex_pkg::MODE_IDLE);
            if (flush_emit && own_has) begin
               out_in                  = flush_tok;
               out_in.last_of_run      = 1'b0;
               out_valid_in            = 1'b1;
               spill_in                = own_tok;
               spill_in.last_of_run    = 1'b1;
               spill_valid_in          = 1'b1;
            end else if (flush_emit) begin
               out_in             = flush_tok;
               out_in.last_of_run = 1'b1;
               out_valid_in       = 1'b1;
            end else if (own_has) begin
               out_in             = own_tok;
               out_in.last_of_run = 1'b1;
               out_valid_in       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= alex_pkg::MODE_IDLE;
         buffer_ff      <= '0;
         count_ff       <= '0;
         accum_ff       <= '0;
         halted_ff      <= 1'b0;
         out_valid_ff   <= 1'b0;
         spill_valid_ff <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         buffer_ff      <= buffer_in;
         count_ff       <= count_in;
         accum_ff       <= accum_in;
         halted_ff      <= halted_in;
         out_valid_ff   <= out_valid_in;
         spill_valid_ff <= spill_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      spill_ff <= spill_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_token = out_ff;

   a_spill_behind_out: assert property (@(posedge clock) disable iff (reset)
      spill_valid_ff |-> out_valid_ff)
      else $error("spill token without result in output register");
   a_halted_clear: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (mode_ff == alex_pkg::MODE_IDLE))
      else $error("pending token while halted");
   a_no_pop_on_spill: assert property (@(posedge clock) disable iff (reset)
      spill_valid_ff |-> !q_pop)
      else $error("item taken while a second token waits");
   a_spill_last: assert property (@(posedge clock) disable iff (reset)
      spill_valid_ff |-> (spill_ff.last_of_run && !out_ff.last_of_run))
      else $error("token pair marked wrongly");

endmodule

// ----- rtl/assignment_lexer_core.sv -----
// Streaming lexer for assignment text: takes one byte or end marker per transfer and
// returns white, punctuation, name, integer, error and end tokens. The front classifies
// each byte into a QUEUE_DEPTH-entry queue; the back holds the lexer state and a result
// register with one spill stage. One byte is taken per cycle while results drain; a byte
// that both closes a pending token and yields its own (punctuation, error, end) gives two
// tokens in turn on the single result port, the second from the spill stage.
// Depends on alex_pkg, alex_front, alex_queue and alex_back.

module assignment_lexer_core #(
   parameter int unsigned NAME_CHARS  = 8,
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [alex_pkg::BYTE_W-1:0]     req_byte_value,
   input  logic                            req_is_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_kind,
   output logic [alex_pkg::VALUE_W-1:0]    rsp_int_value,
   output logic [alex_pkg::TEXT_W-1:0]     rsp_name_text,
   output logic [alex_pkg::LEN_W-1:0]      rsp_name_length,
   output logic [alex_pkg::BYTE_W-1:0]     rsp_bad_char,
   output logic                            rsp_last_of_run
);

   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;
   alex_pkg::item_type  push_item;
   alex_pkg::item_type  pop_item;
   alex_pkg::token_type token;

   alex_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_byte_value (req_byte_value),
      .req_is_end     (req_is_end),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   alex_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   alex_back #(
      .NAME_CHARS (NAME_CHARS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (pop_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_token (token)
   );

   assign rsp_kind        = token.kind;
   assign rsp_int_value   = token.int_value;
   assign rsp_name_text   = token.name_text;
   assign rsp_name_length = token.name_length;
   assign rsp_bad_char    = token.bad_char;
   assign rsp_last_of_run = token.last_of_run;

endmodule

// ----- tb/sv/assignment_lexer_core_tb.sv -----
// self-checking testbench for assignment_lexer_core: a directed table, then random byte runs,
// each transfer checked against a cycle-free token predictor kept in this file
// depends on alex_pkg and the assignment_lexer_core rtl
`timescale 1ns / 100ps

module assignment_lexer_core_tb;

   localparam int NAME_CHARS   = 8;
   localparam int RANDOM_ITEMS = 2000;

   typedef struct packed {
      logic [alex_pkg::BYTE_W-1:0] byte_value;
      logic                        is_end;
      logic                        typed;
      alex_pkg::kind_type          kind;
      logic [alex_pkg::BYTE_W-1:0] bad;
   } stim_type;

   logic                          clock;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic [alex_pkg::BYTE_W-1:0]   req_byte_value = '0;
   logic                          req_is_end     = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic [2:0]                    rsp_kind;
   logic [alex_pkg::VALUE_W-1:0]  rsp_int_value;
   logic [alex_pkg::TEXT_W-1:0]   rsp_name_text;
   logic [alex_pkg::LEN_W-1:0]    rsp_name_length;
   logic [alex_pkg::BYTE_W-1:0]   rsp_bad_char;
   logic                          rsp_last_of_run;

   stim_type                      lex_stream[$];
   alex_pkg::token_type           tokens_due[$];
   alex_pkg::token_type           step_tokens[$];
   int                            send_idx     = 0;
   int                            gap_left     = 0;
   int                            token_errors = 0;
   int                            cycle_count  = 0;
   int                            hold_left    = 0;
   int                            pause_left   = 0;
   logic                          squeeze_go   = 1'b0;
   bit                            squeeze_done = 1'b0;

   // predictor state
   alex_pkg::mode_type            scan_mode    = alex_pkg::MODE_IDLE;
   logic [alex_pkg::TEXT_W-1:0]   name_buf     = '0;
   logic [alex_pkg::LEN_W-1:0]    char_count   = '0;
   logic [alex_pkg::VALUE_W-1:0]  number_acc   = '0;
   bit                            halted       = 1'b0;

   stim_type directed_rows [28] = '{
      '{8'h00,                  1'b1, 1'b1, alex_pkg::KIND_END,    8'h00},
      '{alex_pkg::CHAR_EQUALS,  1'b0, 1'b1, alex_pkg::KIND_EQUALS, 8'h00},
      '{alex_pkg::CHAR_PLUS,    1'b0, 1'b1, alex_pkg::KIND_PLUS,   8'h00},
      '{alex_pkg::CHAR_SEMI,    1'b0, 1'b1, alex_pkg::KIND_SEMI,   8'h00},
      '{alex_pkg::CHAR_SPACE,   1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{alex_pkg::CHAR_NEWLINE, 1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"A",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"b",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"c",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"d",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"e",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"f",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"g",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"Z",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"z",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"9",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"9",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"9",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"9",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"9",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"9",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"9",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"0",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{8'hff,                  1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{"a",                    1'b0, 1'b0, alex_pkg::KIND_WHITE,  8'h00},
      '{8'hff,                  1'b1, 1'b1, alex_pkg::KIND_END,    8'h00},
      '{8'h00,                  1'b0, 1'b1, alex_pkg::KIND_ERROR,  8'h00},
      '{8'h00,                  1'b1, 1'b1, alex_pkg::KIND_END,    8'h00}
   };

   assignment_lexer_core #(
      .NAME_CHARS(NAME_CHARS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_value  (req_byte_value),
      .req_is_end      (req_is_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_int_value   (rsp_int_value),
      .rsp_name_text   (rsp_name_text),
      .rsp_name_length (rsp_name_length),
      .rsp_bad_char    (rsp_bad_char),
      .rsp_last_of_run (rsp_last_of_run)
   );

   function automatic int pick_gap(int phase);
      int r;
      if (phase % 3 == 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic lex_emit(alex_pkg::kind_type k, logic [alex_pkg::VALUE_W-1:0] v,
                           logic [alex_pkg::TEXT_W-1:0] t, logic [alex_pkg::LEN_W-1:0] n,
                           logic [alex_pkg::BYTE_W-1:0] b);
      alex_pkg::token_type tok;
      tok.kind        = k;
      tok.int_value   = v;
      tok.name_text   = t;
      tok.name_length = n;
      tok.bad_char    = b;
      tok.last_of_run = 1'b0;
      step_tokens.push_back(tok);
   endtask

   task automatic lex_flush();
      case (scan_mode)
         alex_pkg::MODE_WHITE: lex_emit(alex_pkg::KIND_WHITE, '0, '0, '0, '0);
         alex_pkg::MODE_NAME:  lex_emit(alex_pkg::KIND_NAME, '0, name_buf, char_count, '0);
         alex_pkg::MODE_INT:   lex_emit(alex_pkg::KIND_INT, number_acc, '0, '0, '0);
         default:              ;
      endcase
      scan_mode  = alex_pkg::MODE_IDLE;
      name_buf   = '0;
      char_count = '0;
      number_acc = '0;
   endtask

   // advance the token state by one accepted byte and queue the tokens it yields, or the row's typed token
   task automatic lex_advance(stim_type it);
      logic [alex_pkg::BYTE_W-1:0] c;
      c = it.byte_value;
      step_tokens.delete();
      if (it.is_end) begin
         lex_flush();
         lex_emit(alex_pkg::KIND_END, '0, '0, '0, '0);
         halted = 1'b0;
      end else if (halted) begin
      end else if (c == alex_pkg::CHAR_SPACE || c == alex_pkg::CHAR_NEWLINE) begin
         if (scan_mode != alex_pkg::MODE_WHITE) begin
            lex_flush();
            scan_mode = alex_pkg::MODE_WHITE;
         end
      end else if (c == alex_pkg::CHAR_EQUALS || c == alex_pkg::CHAR_PLUS ||
                   c == alex_pkg::CHAR_SEMI) begin
         lex_flush();
         lex_emit(c == alex_pkg::CHAR_EQUALS ? alex_pkg::KIND_EQUALS :
                  (c == alex_pkg::CHAR_PLUS ? alex_pkg::KIND_PLUS : alex_pkg::KIND_SEMI),
                  '0, '0, '0, '0);
      end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
         if (scan_mode == alex_pkg::MODE_NAME && char_count < NAME_CHARS) begin
            name_buf   = name_buf | ({56'd0, c} << (8 * char_count));
            char_count = char_count + 1'b1;
         end else begin
            lex_flush();
            scan_mode  = alex_pkg::MODE_NAME;
            name_buf   = {56'd0, c};
            char_count = 4'd1;
         end
      end else if (c >= "0" && c <= "9") begin
         if (scan_mode == alex_pkg::MODE_INT && char_count < NAME_CHARS - 1) begin
            number_acc = number_acc * 24'd10 + 24'(c - "0");
            char_count = char_count + 1'b1;
         end else begin
            lex_flush();
            scan_mode  = alex_pkg::MODE_INT;
            number_acc = 24'(c - "0");
            char_count = 4'd1;
         end
      end else begin
         lex_flush();
         lex_emit(alex_pkg::KIND_ERROR, '0, '0, '0, c);
         halted = 1'b1;
      end
      if (it.typed) begin
         step_tokens.delete();
         lex_emit(it.kind, '0, '0, '0, it.bad);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // sender and checker: result transfers are checked before the new request is predicted
   always @(posedge clock) begin
      alex_pkg::token_type seen;
      alex_pkg::token_type want;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.kind        = alex_pkg::kind_type'(rsp_kind);
            seen.int_value   = rsp_int_value;
            seen.name_text   = rsp_name_text;
            seen.name_length = rsp_name_length;
            seen.bad_char    = rsp_bad_char;
            seen.last_of_run = rsp_last_of_run;
            if (tokens_due.size() == 0) begin
               token_errors++;
               if (token_errors <= 10)
                  $display("unexpected token transfer: kind %0d", rsp_kind);
            end else begin
               want = tokens_due.pop_front();
               if (seen !== want) begin
                  token_errors++;
                  if (token_errors <= 10) begin
                     $display("token mismatch: expected kind %0d int %0d text %h len %0d %s",
                              want.kind, want.int_value, want.name_text,
                              want.name_length, "");
                     $display("   expected bad %h last %b, got kind %0d int %0d text %h",
                              want.bad_char, want.last_of_run,
                              rsp_kind, rsp_int_value, rsp_name_text);
                     $display("   got len %0d bad %h last %b",
                              rsp_name_length, rsp_bad_char, rsp_last_of_run);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            lex_advance(lex_stream[send_idx]);
            send_idx++;
            gap_left = pick_gap(send_idx / 250);
         end
         if (send_idx >= 760) squeeze_go <= 1'b1;
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || send_idx >= lex_stream.size()) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid      <= 1'b1;
               req_byte_value <= lex_stream[send_idx].byte_value;
               req_is_end     <= lex_stream[send_idx].is_end;
            end
         end
      end
   end

   // receiver stalls, with one long hold-off so the queue fills and backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_count++;
         if (squeeze_go && !squeeze_done) begin
            squeeze_done = 1'b1;
            hold_left    = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (pause_left > 0) begin
            pause_left--;
            rsp_stall <= 1'b1;
         end else begin
            pause_left = pick_gap(cycle_count / 500);
            rsp_stall <= (pause_left > 0);
            if (pause_left > 0) pause_left--;
         end
      end
   end

   initial begin
      stim_type   it;
      int         sel;
      int         live;
      int         len;
      foreach (directed_rows[i]) lex_stream.push_back(directed_rows[i]);
      live = 0;
      while (live < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         it  = '{8'h00, 1'b0, 1'b0, alex_pkg::KIND_WHITE, 8'h00};
         if (sel < 26) begin
            len = $urandom_range(1, 12);
            repeat (len) begin
               it.byte_value = ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
               lex_stream.push_back(it);
            end
            live += len;
         end else if (sel < 48) begin
            len = $urandom_range(1, 10);
            repeat (len) begin
               it.byte_value = "0" + 8'($urandom_range(0, 9));
               lex_stream.push_back(it);
            end
            live += len;
         end else if (sel < 62) begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               it.byte_value = $urandom_range(0, 1) ? alex_pkg::CHAR_SPACE
                                                    : alex_pkg::CHAR_NEWLINE;
               lex_stream.push_back(it);
            end
            live += len;
         end else if (sel < 80) begin
            case ($urandom_range(0, 2))
               0:       it.byte_value = alex_pkg::CHAR_EQUALS;
               1:       it.byte_value = alex_pkg::CHAR_PLUS;
               default: it.byte_value = alex_pkg::CHAR_SEMI;
            endcase
            lex_stream.push_back(it);
            live++;
         end else if (sel < 90) begin
            it.byte_value = 8'($urandom_range(0, 255));
            it.is_end     = 1'b1;
            lex_stream.push_back(it);
            live++;
         end else if (sel < 95) begin
            // one to five random bytes, then the end marker
            len = $urandom_range(1, 5);
            repeat (len) begin
               it.byte_value = 8'($urandom_range(0, 255));
               lex_stream.push_back(it);
            end
            it.byte_value = 8'($urandom_range(0, 255));
            it.is_end     = 1'b1;
            lex_stream.push_back(it);
            live += len + 1;
         end else begin
            it.byte_value = 8'($urandom_range(0, 255));
            lex_stream.push_back(it);
            live++;
         end
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (send_idx < lex_stream.size() || tokens_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (token_errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- assignment_lexer_core.f -----
rtl/alex_pkg.sv
rtl/alex_front.sv
rtl/alex_queue.sv
rtl/alex_back.sv
rtl/assignment_lexer_core.sv
tb/sv/assignment_lexer_core_tb.sv
